// ----- src/ksrp_pkg.sv -----
// shared types, codes and constants for the k-step relax / pivot select block
// no dependencies
`default_nettype none

package ksrp_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 4096;

  localparam int DIST_BITS  = 32;
  localparam int VX_W       = 10;
  localparam int OP_W       = 3;
  localparam int K_W        = 5;
  localparam int VC_W       = 11;
  localparam int CNT_W      = 11;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIST_BITS-1:0] DIST_INF = '1;

  localparam logic [K_W-1:0]  K_STEPS_RST      = K_W'(4);
  localparam logic [VC_W-1:0] VERTEX_COUNT_RST = VC_W'(1024);

  localparam logic [CFG_IDX_W-1:0] CFG_K_STEPS      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_SET_DIST = 3'd1,
    OP_ADD_EDGE = 3'd2,
    OP_ADD_SRC  = 3'd3,
    OP_RUN      = 3'd4,
    OP_READ     = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_SRC_WR, S_RD_WAIT,
    S_INIT_RD, S_INIT_WR, S_RND_START,
    S_E_RD, S_E_SRC, S_E_CALC, S_E_CMP,
    S_ADV_RD, S_ADV_WR, S_CHECK,
    S_EARLY_RD, S_EARLY_WR,
    S_CH_RD, S_CH_TST, S_CH_WALK,
    S_PV_RD, S_PV_WR, S_POST
  } state_t;

  typedef struct packed {
    logic [K_W-1:0]  k_steps;
    logic [VC_W-1:0] vertex_count;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [VX_W-1:0]      vertex;
    logic [VX_W-1:0]      edge_dest;
    logic [DIST_BITS-1:0] weight;
    logic [DIST_BITS-1:0] distance;
    logic [DIST_BITS-1:0] bound;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic                 stopped_early;
    logic [CNT_W-1:0]     nearby_count;
    logic [CNT_W-1:0]     pivot_count;
    logic [DIST_BITS-1:0] vertex_distance;
    logic                 in_nearby;
    logic                 is_pivot;
  } res_t;

  typedef struct packed {
    logic [VX_W-1:0]      src;
    logic [VX_W-1:0]      dst;
    logic [DIST_BITS-1:0] wt;
  } edge_word_t;

endpackage

`default_nettype wire

// ----- src/ksrp_if.sv -----
// request channel interfaces: input items, result items, config writes
// depends on ksrp_pkg
`default_nettype none

interface ksrp_in_if;
  logic                           valid;
  logic                           ready;
  logic [ksrp_pkg::OP_W-1:0]      op;
  logic [ksrp_pkg::VX_W-1:0]      vertex;
  logic [ksrp_pkg::VX_W-1:0]      edge_dest;
  logic [ksrp_pkg::DIST_BITS-1:0] weight;
  logic [ksrp_pkg::DIST_BITS-1:0] distance;
  logic [ksrp_pkg::DIST_BITS-1:0] bound;
  modport source (output valid, op, vertex, edge_dest, weight, distance, bound,
                  input ready);
  modport sink (input valid, op, vertex, edge_dest, weight, distance, bound,
                output ready);
endinterface

interface ksrp_out_if;
  logic                           valid;
  logic                           ready;
  logic [ksrp_pkg::STAT_W-1:0]    status;
  logic                           stopped_early;
  logic [ksrp_pkg::CNT_W-1:0]     nearby_count;
  logic [ksrp_pkg::CNT_W-1:0]     pivot_count;
  logic [ksrp_pkg::DIST_BITS-1:0] vertex_distance;
  logic                           in_nearby;
  logic                           is_pivot;
  modport source (output valid, status, stopped_early, nearby_count, pivot_count,
                  vertex_distance, in_nearby, is_pivot, input ready);
  modport sink (input valid, status, stopped_early, nearby_count, pivot_count,
                vertex_distance, in_nearby, is_pivot, output ready);
endinterface

interface ksrp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ksrp_pkg::CFG_IDX_W-1:0]  index;
  logic [ksrp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/ksrp_arith.sv -----
// shared arithmetic unit: saturating distance add and distance compares
// depends on ksrp_pkg
`default_nettype none

module ksrp_arith (
  input  wire logic [ksrp_pkg::DIST_BITS-1:0] add_a,
  input  wire logic [ksrp_pkg::DIST_BITS-1:0] add_b,
  output logic      [ksrp_pkg::DIST_BITS-1:0] sum,
  input  wire logic [ksrp_pkg::DIST_BITS-1:0] cmp_x,
  input  wire logic [ksrp_pkg::DIST_BITS-1:0] cmp_y,
  input  wire logic [ksrp_pkg::DIST_BITS-1:0] cmp_bound,
  output logic                                x_le_y,
  output logic                                x_lt_bound
);
  logic [ksrp_pkg::DIST_BITS:0] raw;

  // carry out means the sum passed infinity
  assign raw        = {1'b0, add_a} + {1'b0, add_b};
  assign sum        = raw[ksrp_pkg::DIST_BITS] ? ksrp_pkg::DIST_INF
                                               : raw[ksrp_pkg::DIST_BITS-1:0];
  assign x_le_y     = (cmp_x <= cmp_y);
  assign x_lt_bound = (cmp_x < cmp_bound);
endmodule

`default_nettype wire

// ----- src/ksrp_seq.sv -----
// sequencer with distance, edge and per-vertex memories
// depends on ksrp_pkg and ksrp_arith
`default_nettype none

module ksrp_seq #(
  parameter int MAX_VERTICES = ksrp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = ksrp_pkg::MAX_EDGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ksrp_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ksrp_pkg::in_item_t in_item,
  input  wire logic               out_free,
  output logic                    post,
  output ksrp_pkg::res_t          res
);
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int DB = ksrp_pkg::DIST_BITS;
  localparam logic [NW-1:0] NONE = NW'(MAX_VERTICES);
  localparam logic [NW-1:0] MAXV = NW'(MAX_VERTICES);

  typedef struct packed {
    logic          src;
    logic          fnow;
    logic          fnext;
    logic          near;
    logic          piv;
    logic [NW-1:0] par;
    logic [NW-1:0] tree;
  } vword_t;

  // memories
  vword_t                vmem [MAX_VERTICES];
  logic [DB-1:0]         dmem [MAX_VERTICES];
  ksrp_pkg::edge_word_t  emem [MAX_EDGES];

  vword_t               vm_rd, vm_wdata;
  logic [VW-1:0]        vm_raddr, vm_waddr;
  logic                 vm_we;
  logic [DB-1:0]        dm_rd, dm_wdata;
  logic [VW-1:0]        dm_raddr, dm_waddr;
  logic                 dm_we;
  ksrp_pkg::edge_word_t em_rd, em_wdata;
  logic [EA-1:0]        em_raddr, em_waddr;
  logic                 em_we;

  always_ff @(posedge clk) begin
    if (vm_we) vmem[vm_waddr] <= vm_wdata;
    vm_rd <= vmem[vm_raddr];
  end
  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
    dm_rd <= dmem[dm_raddr];
  end
  always_ff @(posedge clk) begin
    if (em_we) emem[em_waddr] <= em_wdata;
    em_rd <= emem[em_raddr];
  end

  ksrp_pkg::state_t     state_r, state_nxt;
  logic                 from_op_r, from_op_nxt;
  logic [EW-1:0]        etot_r, etot_nxt;
  logic [EW-1:0]        e_r, e_nxt;
  logic [NW-1:0]        v_r, v_nxt;
  logic [ksrp_pkg::K_W-1:0] r_r, r_nxt;
  logic [NW-1:0]        s_r, s_nxt, w_r, w_nxt, p_r, p_nxt;
  logic [NW-1:0]        cur_r, cur_nxt, steps_r, steps_nxt;
  logic [ksrp_pkg::VX_W-1:0] u_r, u_nxt, t_r, t_nxt;
  logic [DB-1:0]        wt_r, wt_nxt, nd_r, nd_nxt, bd_r, bd_nxt;
  logic [ksrp_pkg::VX_W-1:0] vx_r, vx_nxt;
  ksrp_pkg::res_t       res_r, res_nxt;

  logic [NW-1:0]        n;
  logic [NW+ksrp_pkg::K_W-1:0] ks;
  logic [DB-1:0]        sum;
  logic                 le, lt_b;
  vword_t               clr_word;

  assign n  = (cfg.vertex_count < MAX_VERTICES) ? NW'(cfg.vertex_count) : MAXV;
  assign ks = (NW+ksrp_pkg::K_W)'(cfg.k_steps) * (NW+ksrp_pkg::K_W)'(s_r);

  always_comb begin
    clr_word     = '0;
    clr_word.par = NONE;
  end

  ksrp_arith u_arith (
    .add_a     (dm_rd),
    .add_b     (wt_r),
    .sum       (sum),
    .cmp_x     (nd_r),
    .cmp_y     (dm_rd),
    .cmp_bound (bd_r),
    .x_le_y    (le),
    .x_lt_bound(lt_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ksrp_pkg::S_CLR;
      from_op_r <= 1'b0;
      etot_r    <= '0;
      v_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      from_op_r <= from_op_nxt;
      etot_r    <= etot_nxt;
      v_r       <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt; r_r <= r_nxt; s_r <= s_nxt; w_r <= w_nxt; p_r <= p_nxt;
    cur_r <= cur_nxt; steps_r <= steps_nxt; u_r <= u_nxt; t_r <= t_nxt;
    wt_r <= wt_nxt; nd_r <= nd_nxt; bd_r <= bd_nxt; vx_r <= vx_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r; from_op_nxt = from_op_r; etot_nxt = etot_r;
    e_nxt = e_r; v_nxt = v_r; r_nxt = r_r; s_nxt = s_r; w_nxt = w_r; p_nxt = p_r;
    cur_nxt = cur_r; steps_nxt = steps_r; u_nxt = u_r; t_nxt = t_r;
    wt_nxt = wt_r; nd_nxt = nd_r; bd_nxt = bd_r; vx_nxt = vx_r; res_nxt = res_r;
    vm_raddr = VW'(v_r); vm_we = 1'b0; vm_waddr = VW'(v_r); vm_wdata = vm_rd;
    dm_raddr = VW'(v_r); dm_we = 1'b0; dm_waddr = VW'(in_item.vertex);
    dm_wdata = in_item.distance;
    em_raddr = EA'(e_r); em_we = 1'b0; em_waddr = EA'(etot_r);
    em_wdata = '{src: in_item.vertex, dst: in_item.edge_dest, wt: in_item.weight};
    in_ready = 1'b0;
    post     = 1'b0;

    case (state_r)
      ksrp_pkg::S_CLR: begin
        if (v_r == MAXV) begin
          v_nxt     = '0;
          state_nxt = from_op_r ? ksrp_pkg::S_POST : ksrp_pkg::S_IDLE;
        end else begin
          vm_we    = 1'b1;
          vm_wdata = clr_word;
          v_nxt    = v_r + NW'(1);
        end
      end
      ksrp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        vm_raddr = VW'(in_item.vertex);
        dm_raddr = VW'(in_item.vertex);
        if (in_valid) begin
          res_nxt   = '0;
          vx_nxt    = in_item.vertex;
          bd_nxt    = in_item.bound;
          state_nxt = ksrp_pkg::S_POST;
          case (ksrp_pkg::op_t'(in_item.op))
            ksrp_pkg::OP_CLEAR: begin
              etot_nxt    = '0;
              v_nxt       = '0;
              from_op_nxt = 1'b1;
              state_nxt   = ksrp_pkg::S_CLR;
            end
            ksrp_pkg::OP_SET_DIST: begin
              if (in_item.vertex >= n) res_nxt.status = ksrp_pkg::ST_RANGE;
              else dm_we = 1'b1;
            end
            ksrp_pkg::OP_ADD_EDGE: begin
              if (in_item.vertex >= n || in_item.edge_dest >= n)
                res_nxt.status = ksrp_pkg::ST_RANGE;
              else if (etot_r >= EW'(MAX_EDGES))
                res_nxt.status = ksrp_pkg::ST_FULL;
              else begin
                em_we    = 1'b1;
                etot_nxt = etot_r + EW'(1);
              end
            end
            ksrp_pkg::OP_ADD_SRC: begin
              if (in_item.vertex >= n) res_nxt.status = ksrp_pkg::ST_RANGE;
              else state_nxt = ksrp_pkg::S_SRC_WR;
            end
            ksrp_pkg::OP_RUN: begin
              v_nxt     = '0;
              s_nxt     = '0;
              w_nxt     = '0;
              p_nxt     = '0;
              state_nxt = ksrp_pkg::S_INIT_RD;
            end
            ksrp_pkg::OP_READ: begin
              if (in_item.vertex >= n) res_nxt.status = ksrp_pkg::ST_RANGE;
              else state_nxt = ksrp_pkg::S_RD_WAIT;
            end
            default: ;
          endcase
        end
      end
      ksrp_pkg::S_SRC_WR: begin
        vm_we        = 1'b1;
        vm_waddr     = VW'(vx_r);
        vm_wdata.src = 1'b1;
        state_nxt    = ksrp_pkg::S_POST;
      end
      ksrp_pkg::S_RD_WAIT: begin
        res_nxt.vertex_distance = dm_rd;
        res_nxt.in_nearby       = vm_rd.near;
        res_nxt.is_pivot        = vm_rd.piv;
        state_nxt               = ksrp_pkg::S_POST;
      end
      // run setup: clear run state everywhere, seed frontier and W from S
      ksrp_pkg::S_INIT_RD: begin
        if (v_r == MAXV) begin
          w_nxt = s_r;
          r_nxt = '0;
          v_nxt = '0;
          state_nxt = (cfg.k_steps == '0) ? ksrp_pkg::S_CH_RD : ksrp_pkg::S_RND_START;
        end else begin
          state_nxt = ksrp_pkg::S_INIT_WR;
        end
      end
      ksrp_pkg::S_INIT_WR: begin
        vm_we        = 1'b1;
        vm_wdata     = clr_word;
        vm_wdata.src = vm_rd.src;
        if (vm_rd.src && v_r < n) begin
          vm_wdata.fnow = 1'b1;
          vm_wdata.near = 1'b1;
          s_nxt         = s_r + NW'(1);
        end
        v_nxt     = v_r + NW'(1);
        state_nxt = ksrp_pkg::S_INIT_RD;
      end
      ksrp_pkg::S_RND_START: begin
        e_nxt     = '0;
        state_nxt = ksrp_pkg::S_E_RD;
      end
      ksrp_pkg::S_E_RD: begin
        if (e_r >= etot_r) begin
          v_nxt     = '0;
          state_nxt = ksrp_pkg::S_ADV_RD;
        end else begin
          state_nxt = ksrp_pkg::S_E_SRC;
        end
      end
      ksrp_pkg::S_E_SRC: begin
        u_nxt    = em_rd.src;
        t_nxt    = em_rd.dst;
        wt_nxt   = em_rd.wt;
        vm_raddr = VW'(em_rd.src);
        dm_raddr = VW'(em_rd.src);
        if (em_rd.src >= n || em_rd.dst >= n) begin
          e_nxt     = e_r + EW'(1);
          state_nxt = ksrp_pkg::S_E_RD;
        end else begin
          state_nxt = ksrp_pkg::S_E_CALC;
        end
      end
      ksrp_pkg::S_E_CALC: begin
        vm_raddr = VW'(t_r);
        dm_raddr = VW'(t_r);
        nd_nxt   = sum;
        if (!vm_rd.fnow) begin
          e_nxt     = e_r + EW'(1);
          state_nxt = ksrp_pkg::S_E_RD;
        end else begin
          state_nxt = ksrp_pkg::S_E_CMP;
        end
      end
      ksrp_pkg::S_E_CMP: begin
        if (le) begin
          dm_we          = 1'b1;
          dm_waddr       = VW'(t_r);
          dm_wdata       = nd_r;
          vm_we          = 1'b1;
          vm_waddr       = VW'(t_r);
          vm_wdata.par   = NW'(u_r);
          vm_wdata.fnext = vm_rd.fnext | lt_b;
        end
        e_nxt     = e_r + EW'(1);
        state_nxt = ksrp_pkg::S_E_RD;
      end
      // end of round: next frontier becomes current, grow W
      ksrp_pkg::S_ADV_RD: begin
        state_nxt = (v_r >= n) ? ksrp_pkg::S_CHECK : ksrp_pkg::S_ADV_WR;
      end
      ksrp_pkg::S_ADV_WR: begin
        vm_we          = 1'b1;
        vm_wdata.fnow  = vm_rd.fnext;
        vm_wdata.fnext = 1'b0;
        vm_wdata.near  = vm_rd.near | vm_rd.fnext;
        if (vm_rd.fnext && !vm_rd.near) w_nxt = w_r + NW'(1);
        v_nxt     = v_r + NW'(1);
        state_nxt = ksrp_pkg::S_ADV_RD;
      end
      ksrp_pkg::S_CHECK: begin
        v_nxt = '0;
        r_nxt = r_r + ksrp_pkg::K_W'(1);
        if ((NW+ksrp_pkg::K_W)'(w_r) > ks) state_nxt = ksrp_pkg::S_EARLY_RD;
        else if (r_r + ksrp_pkg::K_W'(1) < cfg.k_steps) state_nxt = ksrp_pkg::S_RND_START;
        else state_nxt = ksrp_pkg::S_CH_RD;
      end
      ksrp_pkg::S_EARLY_RD: begin
        if (v_r >= n) begin
          res_nxt.stopped_early = 1'b1;
          res_nxt.nearby_count  = ksrp_pkg::CNT_W'(w_r);
          res_nxt.pivot_count   = ksrp_pkg::CNT_W'(s_r);
          state_nxt             = ksrp_pkg::S_POST;
        end else begin
          state_nxt = ksrp_pkg::S_EARLY_WR;
        end
      end
      ksrp_pkg::S_EARLY_WR: begin
        vm_we        = 1'b1;
        vm_wdata.piv = vm_rd.src;
        v_nxt        = v_r + NW'(1);
        state_nxt    = ksrp_pkg::S_EARLY_RD;
      end
      // chain walk from each W member to its root
      ksrp_pkg::S_CH_RD: begin
        if (v_r >= n) begin
          v_nxt     = '0;
          state_nxt = ksrp_pkg::S_PV_RD;
        end else begin
          state_nxt = ksrp_pkg::S_CH_TST;
        end
      end
      ksrp_pkg::S_CH_TST: begin
        if (!vm_rd.near) begin
          v_nxt     = v_r + NW'(1);
          state_nxt = ksrp_pkg::S_CH_RD;
        end else begin
          cur_nxt   = v_r;
          steps_nxt = '0;
          state_nxt = ksrp_pkg::S_CH_WALK;
        end
      end
      ksrp_pkg::S_CH_WALK: begin
        if (steps_r < n && vm_rd.par < n) begin
          cur_nxt   = vm_rd.par;
          steps_nxt = steps_r + NW'(1);
          vm_raddr  = VW'(vm_rd.par);
        end else begin
          vm_we         = 1'b1;
          vm_waddr      = VW'(cur_r);
          vm_wdata.tree = vm_rd.tree + NW'(1);
          v_nxt         = v_r + NW'(1);
          state_nxt     = ksrp_pkg::S_CH_RD;
        end
      end
      ksrp_pkg::S_PV_RD: begin
        if (v_r >= n) begin
          res_nxt.nearby_count = ksrp_pkg::CNT_W'(w_r);
          res_nxt.pivot_count  = ksrp_pkg::CNT_W'(p_r);
          state_nxt            = ksrp_pkg::S_POST;
        end else begin
          state_nxt = ksrp_pkg::S_PV_WR;
        end
      end
      ksrp_pkg::S_PV_WR: begin
        if (vm_rd.tree != '0 && vm_rd.tree >= NW'(cfg.k_steps)) begin
          vm_we        = 1'b1;
          vm_wdata.piv = 1'b1;
          p_nxt        = p_r + NW'(1);
        end
        v_nxt     = v_r + NW'(1);
        state_nxt = ksrp_pkg::S_PV_RD;
      end
      ksrp_pkg::S_POST: begin
        if (out_free) begin
          post      = 1'b1;
          state_nxt = ksrp_pkg::S_IDLE;
        end
      end
      default: state_nxt = ksrp_pkg::S_IDLE;
    endcase
  end

  assign res = res_r;
endmodule

`default_nettype wire

// ----- src/k_step_relax_pivot_select.sv -----
// k-step bellman-ford relaxation with pivot selection, top level
// depends on ksrp_pkg, ksrp_if and ksrp_seq
// set, add edge and unused ops post from idle; add to S and read pass one more state;
//   clear sweeps the vertex memory; run sweeps it, then up to k rounds and the pivot passes
// throughput: one request at a time, next accepted once the sequencer is idle
// reset: clearing pass over the whole vertex memory, no request taken
`default_nettype none

module k_step_relax_pivot_select #(
  parameter int MAX_VERTICES = ksrp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = ksrp_pkg::MAX_EDGES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ksrp_in_if.sink    in_ch,
  ksrp_out_if.source out_ch,
  ksrp_cfg_if.sink   cfg_ch
);
  // configuration registers, to be written only while idle; the block does not enforce it
  logic [ksrp_pkg::K_W-1:0]  k_steps_r;
  logic [ksrp_pkg::VC_W-1:0] vertex_count_r;
  ksrp_pkg::cfg_t            cfg;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_steps_r      <= ksrp_pkg::K_STEPS_RST;
      vertex_count_r <= ksrp_pkg::VERTEX_COUNT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ksrp_pkg::CFG_K_STEPS:      k_steps_r <= cfg_ch.data[ksrp_pkg::K_W-1:0];
        ksrp_pkg::CFG_VERTEX_COUNT: vertex_count_r <= cfg_ch.data[ksrp_pkg::VC_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.k_steps      = k_steps_r;
  assign cfg.vertex_count = vertex_count_r;

  // input request bundle
  ksrp_pkg::in_item_t item;
  assign item.op        = in_ch.op;
  assign item.vertex    = in_ch.vertex;
  assign item.edge_dest = in_ch.edge_dest;
  assign item.weight    = in_ch.weight;
  assign item.distance  = in_ch.distance;
  assign item.bound     = in_ch.bound;

  // output register: sequencer posts into it when free or being drained
  logic           out_valid_r;
  ksrp_pkg::res_t out_res_r;
  ksrp_pkg::res_t seq_res;
  logic           post;
  logic           out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  ksrp_seq #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_item (item),
    .out_free(out_free),
    .post    (post),
    .res     (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (post) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (post) out_res_r <= seq_res;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_res_r.status;
  assign out_ch.stopped_early   = out_res_r.stopped_early;
  assign out_ch.nearby_count    = out_res_r.nearby_count;
  assign out_ch.pivot_count     = out_res_r.pivot_count;
  assign out_ch.vertex_distance = out_res_r.vertex_distance;
  assign out_ch.in_nearby       = out_res_r.in_nearby;
  assign out_ch.is_pivot        = out_res_r.is_pivot;
endmodule

`default_nettype wire

// ----- tb/tb_k_step_relax_pivot_select.sv -----
// self-checking testbench for k_step_relax_pivot_select: graph loads, runs, reads
// depends on ksrp_pkg, ksrp_if and the block's rtl
`timescale 1ns / 1ps

module tb_k_step_relax_pivot_select;

  localparam int NV        = 1024;
  localparam int NE        = 4096;
  localparam int POOL      = 12;
  localparam int CYC_LIMIT = 6000000;

  // op codes the block treats as no-ops
  localparam logic [ksrp_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [ksrp_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;

  ksrp_in_if  in_bus ();
  ksrp_out_if out_bus ();
  ksrp_cfg_if cfg_bus ();

  k_step_relax_pivot_select u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // clock, 8 ns period
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // shadow of the block's state for prediction
  logic [ksrp_pkg::DIST_BITS-1:0] dist_mem [NV];
  logic [ksrp_pkg::VX_W-1:0]      e_src [NE];
  logic [ksrp_pkg::VX_W-1:0]      e_dst [NE];
  logic [ksrp_pkg::DIST_BITS-1:0] e_wt [NE];
  int                             e_total;
  bit                             in_s [NV];
  bit                             f_now [NV];
  bit                             f_next [NV];
  bit                             in_w [NV];
  bit                             piv [NV];
  int                             par [NV];
  int                             tcnt [NV];
  int                             k_cur;
  int                             vc_cur;

  ksrp_pkg::res_t expected_q [$];
  int   errors;
  int   cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;

  function automatic int used_n();
    return (vc_cur < NV) ? vc_cur : NV;
  endfunction

  function automatic void clear_walk_state();
    for (int v = 0; v < NV; v++) begin
      f_now[v] = 0; f_next[v] = 0; in_w[v] = 0; piv[v] = 0;
      tcnt[v] = 0; par[v] = NV;
    end
  endfunction

  // k rounds of relaxation from S, then early stop or root counting
  function automatic ksrp_pkg::res_t relax_and_pick(logic [ksrp_pkg::DIST_BITS-1:0] bound);
    ksrp_pkg::res_t r;
    int n, s_sz, w_sz, p_cnt, u, t, cur, steps;
    logic [ksrp_pkg::DIST_BITS:0] sum;
    logic [ksrp_pkg::DIST_BITS-1:0] nd;
    n = used_n();
    r = '0;
    s_sz = 0;
    p_cnt = 0;
    clear_walk_state();
    for (int v = 0; v < n; v++) begin
      if (in_s[v]) begin
        f_now[v] = 1; in_w[v] = 1; s_sz++;
      end
    end
    w_sz = s_sz;
    for (int rnd = 0; rnd < k_cur; rnd++) begin
      for (int v = 0; v < NV; v++) f_next[v] = 0;
      for (int e = 0; e < e_total; e++) begin
        u = e_src[e];
        t = e_dst[e];
        if (u >= n || t >= n || !f_now[u]) continue;
        sum = {1'b0, dist_mem[u]} + {1'b0, e_wt[e]};
        nd = (sum > {1'b0, ksrp_pkg::DIST_INF}) ? ksrp_pkg::DIST_INF
                                                : sum[ksrp_pkg::DIST_BITS-1:0];
        if (nd <= dist_mem[t]) begin
          dist_mem[t] = nd;
          par[t] = u;
          if (nd < bound) f_next[t] = 1;
        end
      end
      for (int v = 0; v < n; v++) begin
        f_now[v] = f_next[v];
        if (f_next[v] && !in_w[v]) begin
          in_w[v] = 1; w_sz++;
        end
      end
      if (w_sz > k_cur * s_sz) begin
        for (int v = 0; v < n; v++) piv[v] = in_s[v];
        r.stopped_early = 1'b1;
        r.nearby_count = ksrp_pkg::CNT_W'(w_sz);
        r.pivot_count = ksrp_pkg::CNT_W'(s_sz);
        return r;
      end
    end
    // walk each chain to its root, bounded by n steps against zero-weight loops
    for (int v = 0; v < n; v++) begin
      if (!in_w[v]) continue;
      cur = v;
      steps = 0;
      while (steps < n && par[cur] < n) begin
        cur = par[cur];
        steps++;
      end
      tcnt[cur]++;
    end
    for (int v = 0; v < n; v++) begin
      if (tcnt[v] > 0 && tcnt[v] >= k_cur) begin
        piv[v] = 1; p_cnt++;
      end
    end
    r.nearby_count = ksrp_pkg::CNT_W'(w_sz);
    r.pivot_count = ksrp_pkg::CNT_W'(p_cnt);
    return r;
  endfunction

  // expected result of one request, updating the shadow state
  function automatic ksrp_pkg::res_t predict_result(ksrp_pkg::in_item_t it);
    ksrp_pkg::res_t r;
    int n;
    n = used_n();
    r = '0;
    r.status = ksrp_pkg::ST_OK;
    case (it.op)
      ksrp_pkg::OP_CLEAR: begin
        e_total = 0;
        for (int v = 0; v < NV; v++) in_s[v] = 0;
        clear_walk_state();
      end
      ksrp_pkg::OP_SET_DIST: begin
        if (it.vertex >= n) r.status = ksrp_pkg::ST_RANGE;
        else dist_mem[it.vertex] = it.distance;
      end
      ksrp_pkg::OP_ADD_EDGE: begin
        if (it.vertex >= n || it.edge_dest >= n) r.status = ksrp_pkg::ST_RANGE;
        else if (e_total >= NE) r.status = ksrp_pkg::ST_FULL;
        else begin
          e_src[e_total] = it.vertex;
          e_dst[e_total] = it.edge_dest;
          e_wt[e_total] = it.weight;
          e_total++;
        end
      end
      ksrp_pkg::OP_ADD_SRC: begin
        if (it.vertex >= n) r.status = ksrp_pkg::ST_RANGE;
        else in_s[it.vertex] = 1;
      end
      ksrp_pkg::OP_RUN: r = relax_and_pick(it.bound);
      ksrp_pkg::OP_READ: begin
        if (it.vertex >= n) r.status = ksrp_pkg::ST_RANGE;
        else begin
          r.vertex_distance = dist_mem[it.vertex];
          r.in_nearby = in_w[it.vertex];
          r.is_pivot = piv[it.vertex];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string nm, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, nm, exp_v, act_v);
    end
  endfunction

  // cycle count and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    ksrp_pkg::res_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result, status %0d", $realtime, out_bus.status);
      end else begin
        exp_r = expected_q.pop_front();
        check_field("status", exp_r.status, out_bus.status);
        check_field("stopped_early", exp_r.stopped_early, out_bus.stopped_early);
        check_field("nearby_count", exp_r.nearby_count, out_bus.nearby_count);
        check_field("pivot_count", exp_r.pivot_count, out_bus.pivot_count);
        check_field("vertex_distance", exp_r.vertex_distance, out_bus.vertex_distance);
        check_field("in_nearby", exp_r.in_nearby, out_bus.in_nearby);
        check_field("is_pivot", exp_r.is_pivot, out_bus.is_pivot);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one request on the input channel; called at a falling edge, returns at one
  task automatic send_req(logic [ksrp_pkg::OP_W-1:0] op, logic [ksrp_pkg::VX_W-1:0] vx,
                          logic [ksrp_pkg::VX_W-1:0] dst,
                          logic [ksrp_pkg::DIST_BITS-1:0] wt,
                          logic [ksrp_pkg::DIST_BITS-1:0] dv,
                          logic [ksrp_pkg::DIST_BITS-1:0] bd);
    ksrp_pkg::in_item_t it;
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    it = '{op: op, vertex: vx, edge_dest: dst, weight: wt, distance: dv, bound: bd};
    in_bus.valid = 1'b1;
    in_bus.op = op;
    in_bus.vertex = vx;
    in_bus.edge_dest = dst;
    in_bus.weight = wt;
    in_bus.distance = dv;
    in_bus.bound = bd;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    expected_q.push_back(predict_result(it));
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [ksrp_pkg::CFG_IDX_W-1:0] idx, int val);
    wait_drained();
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = ksrp_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == ksrp_pkg::CFG_K_STEPS) k_cur = val & 'h1f;
    else if (idx == ksrp_pkg::CFG_VERTEX_COUNT) vc_cur = val & 'h7ff;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_config(int k, int vc);
    write_reg(ksrp_pkg::CFG_K_STEPS, k);
    write_reg(ksrp_pkg::CFG_VERTEX_COUNT, vc);
  endtask

  // every vertex of the working pool gets a distance before any read or run
  task automatic test_load_distances();
    for (int v = 0; v < POOL; v++)
      send_req(ksrp_pkg::OP_SET_DIST, ksrp_pkg::VX_W'(v), '0, '0,
               (v % 97 == 5) ? ksrp_pkg::DIST_INF
                             : ksrp_pkg::DIST_BITS'($urandom_range(1000)), '0);
  endtask

  // small hand-built graph: zero-weight loop, saturation, range errors, unused ops
  task automatic test_small_graph();
    set_config(2, 8);
    send_req(ksrp_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    send_req(ksrp_pkg::OP_SET_DIST, 10'd0, '0, '0, '0, '0);
    for (int v = 1; v < 6; v++)
      send_req(ksrp_pkg::OP_SET_DIST, ksrp_pkg::VX_W'(v), '0, '0, ksrp_pkg::DIST_INF, '0);
    send_req(ksrp_pkg::OP_SET_DIST, 10'd7, '0, '0, 32'hffff_fff0, '0);
    send_req(ksrp_pkg::OP_ADD_EDGE, 10'd0, 10'd1, 32'd5, '0, '0);
    send_req(ksrp_pkg::OP_ADD_EDGE, 10'd1, 10'd2, 32'd0, '0, '0);
    send_req(ksrp_pkg::OP_ADD_EDGE, 10'd2, 10'd1, 32'd0, '0, '0);        // zero-weight loop
    send_req(ksrp_pkg::OP_ADD_EDGE, 10'd7, 10'd3, 32'hffff_fffe, '0, '0); // saturates
    send_req(ksrp_pkg::OP_ADD_EDGE, 10'd3, 10'd4, ksrp_pkg::DIST_INF, '0, '0);
    send_req(ksrp_pkg::OP_ADD_EDGE, 10'd8, 10'd1, 32'd1, '0, '0);   // source out of range
    send_req(ksrp_pkg::OP_ADD_EDGE, 10'd1, 10'h3ff, 32'd1, '0, '0); // target out of range
    send_req(ksrp_pkg::OP_SET_DIST, 10'h3ff, '0, '0, 32'd3, '0);
    send_req(ksrp_pkg::OP_ADD_SRC, 10'd0, '0, '0, '0, '0);
    send_req(ksrp_pkg::OP_ADD_SRC, 10'd7, '0, '0, '0, '0);
    send_req(ksrp_pkg::OP_ADD_SRC, 10'd9, '0, '0, '0, '0);
    send_req(ksrp_pkg::OP_RUN, '0, '0, '0, '0, ksrp_pkg::DIST_INF);
    for (int v = 0; v < 8; v++)
      send_req(ksrp_pkg::OP_READ, ksrp_pkg::VX_W'(v), '0, '0, '0, '0);
    send_req(ksrp_pkg::OP_READ, 10'd8, '0, '0, '0, '0);
    send_req(OP_SPARE_LO, 10'h3ff, 10'h3ff, '1, '1, '1);
    send_req(OP_SPARE_HI, '0, '0, '0, '0, '0);
    send_req(ksrp_pkg::OP_RUN, '0, '0, '0, '0, 32'd0);      // bound zero, nothing joins
    send_req(ksrp_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    send_req(ksrp_pkg::OP_RUN, '0, '0, '0, '0, ksrp_pkg::DIST_INF); // empty run
  endtask

  // a pool vertex, or now and then one at or above the vertex count
  function automatic logic [ksrp_pkg::VX_W-1:0] pick_vertex();
    int n;
    n = used_n();
    if (n < NV && $urandom_range(9) == 0)
      return ksrp_pkg::VX_W'($urandom_range(NV - 1, n));
    return ksrp_pkg::VX_W'($urandom_range(POOL - 1));
  endfunction

  function automatic logic [ksrp_pkg::DIST_BITS-1:0] pick_value(int span);
    case ($urandom_range(9))
      0: return ksrp_pkg::DIST_INF;
      1: return ksrp_pkg::DIST_BITS'($urandom());
      2: return '0;
      default: return ksrp_pkg::DIST_BITS'($urandom_range(span));
    endcase
  endfunction

  // mostly well-formed graph building with runs and reads, some noise
  task automatic test_random_traffic(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 6) send_req(ksrp_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
      else if (sel < 22)
        send_req(ksrp_pkg::OP_SET_DIST, pick_vertex(), '0, '0, pick_value(300), '0);
      else if (sel < 52)
        send_req(ksrp_pkg::OP_ADD_EDGE, pick_vertex(), pick_vertex(), pick_value(40), '0, '0);
      else if (sel < 64) send_req(ksrp_pkg::OP_ADD_SRC, pick_vertex(), '0, '0, '0, '0);
      else if (sel < 74) send_req(ksrp_pkg::OP_RUN, '0, '0, '0, '0, pick_value(400));
      else if (sel < 94) send_req(ksrp_pkg::OP_READ, pick_vertex(), '0, '0, '0, '0);
      else
        send_req(ksrp_pkg::OP_W'($urandom_range(7)), pick_vertex(), pick_vertex(),
                 ksrp_pkg::DIST_BITS'($urandom()), ksrp_pkg::DIST_BITS'($urandom()),
                 ksrp_pkg::DIST_BITS'($urandom()));
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_left = 400;
    test_random_traffic(10);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    k_cur = ksrp_pkg::K_STEPS_RST;
    vc_cur = ksrp_pkg::VERTEX_COUNT_RST;
    e_total = 0;
    for (int v = 0; v < NV; v++) begin
      dist_mem[v] = '0; in_s[v] = 0;
    end
    clear_walk_state();
    in_bus.valid = 1'b0;
    in_bus.op = '0;
    in_bus.vertex = '0;
    in_bus.edge_dest = '0;
    in_bus.weight = '0;
    in_bus.distance = '0;
    in_bus.bound = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults before any register write
    test_load_distances();
    test_random_traffic(4);
    test_small_graph();

    // idling phases crossed with register settings, extremes included
    set_config(16, 1024);
    test_random_traffic(8);
    send_idle_pct = 45;
    set_config(1, 1);
    test_random_traffic(6);
    set_config(0, 10);
    test_random_traffic(6);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    set_config(3, 0);
    test_random_traffic(6);
    set_config(16, 12);
    test_random_traffic(8);
    test_backpressure();
    send_idle_pct = 20;
    recv_stall_pct = 20;
    set_config(2, 2047);
    test_random_traffic(6);
    set_config(5, 40);
    test_random_traffic(6);

    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ksrp_pkg.sv
src/ksrp_if.sv
src/ksrp_arith.sv
src/ksrp_seq.sv
src/k_step_relax_pivot_select.sv
tb/tb_k_step_relax_pivot_select.sv
